### src/pfcb_pkg.sv
`timescale 1ns / 1ps

package pfcb_pkg;

  typedef enum logic [2:0] {
    FMT_U8    = 3'd0,
    FMT_U10   = 3'd1,
    FMT_U12   = 3'd2,
    FMT_U14   = 3'd3,
    FMT_S8_7  = 3'd4,
    FMT_S10_5 = 3'd5,
    FMT_S12_3 = 3'd6,
    FMT_S14_1 = 3'd7
  } pfcb_fmt_t;

  typedef enum logic [1:0] {
    REG_SOURCE_FORMAT = 2'd0,
    REG_TARGET_FORMAT = 2'd1,
    REG_BLEND_MODE    = 2'd2
  } pfcb_reg_t;

  localparam int unsigned CFG_DATA_W = 3;

  // bias between unsigned and signed 16-bit sample domains
  localparam logic [15:0] SIGNED_BIAS = 16'd16384;

  typedef struct packed {
    pfcb_fmt_t src_fmt;
    pfcb_fmt_t dst_fmt;
    logic      add_mode;
  } pfcb_cfg_t;

endpackage

### src/pfcb_datapath.sv
`timescale 1ns / 1ps

module pfcb_datapath (
  input  pfcb_pkg::pfcb_cfg_t cfg,
  input  logic signed [15:0]  source_sample,
  input  logic signed [15:0]  prior_target_sample,
  output logic signed [15:0]  result_sample,
  output logic                unsupported
);
  import pfcb_pkg::*;

  function automatic logic [15:0] umask(input logic [1:0] f);
    logic [15:0] m;
    case (f)
      2'd0:    m = 16'h00FF;
      2'd1:    m = 16'h03FF;
      2'd2:    m = 16'h0FFF;
      default: m = 16'h3FFF;
    endcase
    return m;
  endfunction

  function automatic logic signed [15:0] u_to_s(input logic [1:0] f, input logic [15:0] u);
    logic [15:0] sv;
    sv = u << (3'd7 - {f, 1'b0});
    return signed'(sv - SIGNED_BIAS);
  endfunction

  // rounding arithmetic shift, mid offset, clamp to [0, 2^N-1]
  function automatic logic [15:0] s_to_u(input logic [1:0] f, input logic signed [17:0] v);
    logic [2:0]         sh;
    logic signed [17:0] rnd;
    logic signed [17:0] t;
    logic signed [17:0] q;
    logic signed [17:0] maxv;
    logic signed [17:0] w;
    logic [15:0]        res;
    sh   = 3'd7 - {f, 1'b0};
    rnd  = 18'sd1 <<< (sh - 3'd1);
    t    = v + rnd;
    q    = t >>> sh;
    maxv = signed'({2'b00, umask(f)});
    w    = q + (maxv >>> 1) + 18'sd1;
    if (w[17]) begin
      res = '0;
    end else if (w > maxv) begin
      res = maxv[15:0];
    end else begin
      res = w[15:0];
    end
    return res;
  endfunction

  logic               src_sig;
  logic               dst_sig;
  logic [1:0]         sf;
  logic [1:0]         df;
  logic [15:0]        src_u;
  logic [15:0]        dst_u;
  logic               u8_pair;
  logic signed [15:0] addend;
  logic signed [15:0] dst_as_s;
  logic signed [15:0] src_as_s;
  logic signed [17:0] blend_sum;
  logic signed [17:0] conv_in;
  logic [15:0]        to_u;
  logic signed [16:0] sum17;
  logic signed [15:0] sat_sum;

  always_comb begin
    src_sig  = cfg.src_fmt[2];
    dst_sig  = cfg.dst_fmt[2];
    sf       = cfg.src_fmt[1:0];
    df       = cfg.dst_fmt[1:0];
    src_u    = source_sample & umask(sf);
    dst_u    = prior_target_sample & umask(df);
    u8_pair  = (cfg.src_fmt == FMT_U8) && (cfg.dst_fmt == FMT_U8);
    // U8 onto U8: low byte is a signed 8-bit residual scaled by 256
    addend   = u8_pair ? signed'({source_sample[7:0], 8'h00}) : source_sample;
    dst_as_s = u_to_s(df, dst_u);
    src_as_s = u_to_s(sf, src_u);
    blend_sum = {{2{dst_as_s[15]}}, dst_as_s} + {{2{addend[15]}}, addend};
    conv_in  = cfg.add_mode ? blend_sum : {{2{source_sample[15]}}, source_sample};
    to_u     = s_to_u(df, conv_in);
    sum17    = {source_sample[15], source_sample}
             + {prior_target_sample[15], prior_target_sample};
    if (sum17 > 17'sd32767) begin
      sat_sum = 16'sh7FFF;
    end else if (sum17 < -17'sd32768) begin
      sat_sum = 16'sh8000;
    end else begin
      sat_sum = sum17[15:0];
    end

    result_sample = '0;
    unsupported   = 1'b0;
    if (cfg.add_mode) begin
      if (u8_pair) begin
        result_sample = signed'(to_u);
      end else if (dst_sig) begin
        if (cfg.src_fmt == cfg.dst_fmt) begin
          result_sample = sat_sum;
        end else begin
          unsupported = 1'b1;
        end
      end else if (src_sig && (sf == df)) begin
        result_sample = signed'(to_u);
      end else begin
        unsupported = 1'b1;
      end
    end else begin
      if ((cfg.src_fmt == cfg.dst_fmt) || (src_sig && dst_sig)) begin
        result_sample = src_sig ? source_sample : signed'(src_u);
      end else if (!src_sig && !dst_sig) begin
        if (df > sf) begin
          result_sample = signed'(src_u << {df - sf, 1'b0});
        end else if (cfg.dst_fmt == FMT_U8) begin
          result_sample = signed'(src_u >> {sf, 1'b0});
        end else begin
          unsupported = 1'b1;
        end
      end else if (df >= sf) begin
        result_sample = src_sig ? signed'(to_u) : src_as_s;
      end else begin
        unsupported = 1'b1;
      end
    end
  end

endmodule

### src/pixel_format_convert_blend_unit.sv
`timescale 1ns / 1ps
// A word passes the input register, then the result register.
// Throughput: one word per cycle unless out_ready stalls; the input
// register and result register each hold a word, so input is taken
// while a result waits, as long as the input register is empty.
// Reset (rst, synchronous): clears both valid flags and sets all
// configuration registers to 0 (U8 to U8, copy mode).

module pixel_format_convert_blend_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [pfcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            source_sample,
  input  logic signed [15:0]            prior_target_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            result_sample,
  output logic                          unsupported
);
  import pfcb_pkg::*;

  pfcb_cfg_t          cfg;
  logic               s1_valid;
  logic signed [15:0] s1_src;
  logic signed [15:0] s1_prior;
  logic               adv2;
  logic signed [15:0] result_next;
  logic               unsupported_next;

  assign adv2     = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_fmt  <= FMT_U8;
      cfg.dst_fmt  <= FMT_U8;
      cfg.add_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SOURCE_FORMAT: cfg.src_fmt  <= pfcb_fmt_t'(cfg_wdata);
        REG_TARGET_FORMAT: cfg.dst_fmt  <= pfcb_fmt_t'(cfg_wdata);
        REG_BLEND_MODE:    cfg.add_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_src   <= source_sample;
      s1_prior <= prior_target_sample;
    end
    if (s1_valid && adv2) begin
      result_sample <= result_next;
      unsupported   <= unsupported_next;
    end
  end

  pfcb_datapath u_datapath (
    .cfg                 (cfg),
    .source_sample       (s1_src),
    .prior_target_sample (s1_prior),
    .result_sample       (result_next),
    .unsupported         (unsupported_next)
  );

  a_unsup_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported |-> result_sample == 16'sd0)
    else $error("unsupported word carries nonzero sample");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv2 |=> out_valid)
    else $error("word lost between input and result register");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with free pipeline slot");

  a_reset: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("valid flags not cleared by reset");

endmodule
